@@ src/fdc_pkg.sv @@
// shared types, constants and crc helper for the frame deframer with crc-16 check
package fdc_pkg;

    localparam logic [7:0]  START_MARK = 8'hFE;
    localparam logic [7:0]  END_MARK   = 8'hFD;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  INDEX_MAX  = 8'hFF;
    localparam logic [7:0]  CRC_SKIP   = 8'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_CRC_LO = 4'b0010,
        PH_LEN    = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic        crc_ok;
        logic        for_master;
        logic [15:0] frame_crc;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t r0;
        result_t r1;
    } push_t;

    // byte-wide crc-16/modbus update, reflected
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ src/fdc_core.sv @@
// input register, frame parser and crc state; produces up to two results per beat
module fdc_core
    import fdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic [Q_CNT_W-1:0]   room,
    output push_t                push
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        start_armed_reg, start_armed_next;
    logic        end_armed_reg, end_armed_next;
    logic        expect_hi_reg, expect_hi_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [15:0] header_crc_reg, header_crc_next;
    logic [15:0] run_crc_reg, run_crc_next;
    logic [7:0]  dly_reg [3];
    logic [7:0]  dly_next [3];
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [7:0]  count_reg, count_next;

    logic        data_en;
    logic        status_en;
    logic        crc_ok;
    logic [1:0]  n_res;
    logic        fire;
    logic [15:0] crc_fed;
    result_t     data_res;
    result_t     status_res;

    assign crc_fed = crc_feed(run_crc_reg, dly_reg[2]);

    always_comb
    begin
        start_armed_next = start_armed_reg;
        end_armed_next   = end_armed_reg;
        expect_hi_next   = expect_hi_reg;
        phase_next       = phase_reg;
        crc_hi_next      = crc_hi_reg;
        header_crc_next  = header_crc_reg;
        run_crc_next     = run_crc_reg;
        dly_next         = dly_reg;
        first_byte_next  = first_byte_reg;
        count_next       = count_reg;
        data_en          = 1'b0;
        status_en        = 1'b0;
        crc_ok           = 1'b0;

        if (in_byte_reg == START_MARK)
        begin
            if (!start_armed_reg)
            begin
                start_armed_next = 1'b1;
            end
            else
            begin
                start_armed_next = 1'b0;
                expect_hi_next   = 1'b1;
                phase_next       = PH_IDLE;
                first_byte_next  = 8'h00;
                run_crc_next     = CRC_INIT;
                dly_next         = '{8'h00, 8'h00, 8'h00};
                count_next       = 8'h00;
            end
        end
        else if (expect_hi_reg)
        begin
            crc_hi_next    = in_byte_reg;
            expect_hi_next = 1'b0;
            phase_next     = PH_CRC_LO;
        end
        else
        begin
            unique case (phase_reg)
                PH_CRC_LO:
                begin
                    header_crc_next = {crc_hi_reg, in_byte_reg};
                    phase_next      = PH_LEN;
                end
                PH_LEN:
                begin
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    data_en = 1'b1;
                    if (count_reg == 8'h00)
                    begin
                        first_byte_next = in_byte_reg;
                    end
                    // crc lags three bytes behind the payload
                    if (count_reg >= CRC_SKIP)
                    begin
                        run_crc_next = crc_fed;
                    end
                    dly_next[2] = dly_reg[1];
                    dly_next[1] = dly_reg[0];
                    dly_next[0] = in_byte_reg;
                    if (count_reg != INDEX_MAX)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (in_byte_reg == END_MARK)
        begin
            if (!end_armed_reg)
            begin
                end_armed_next = 1'b1;
            end
            else
            begin
                end_armed_next = 1'b0;
                status_en      = 1'b1;
                crc_ok         = (run_crc_next == header_crc_next);
                phase_next     = PH_IDLE;
                run_crc_next   = CRC_INIT;
                dly_next       = '{8'h00, 8'h00, 8'h00};
                count_next     = 8'h00;
            end
        end
    end

    always_comb
    begin
        data_res              = '0;
        data_res.kind         = KIND_DATA;
        data_res.data_byte    = in_byte_reg;
        data_res.data_index   = count_reg;
        data_res.last         = !status_en;

        status_res            = '0;
        status_res.kind       = KIND_STATUS;
        status_res.crc_ok     = crc_ok;
        status_res.for_master = crc_ok && (first_byte_next == 8'h00);
        status_res.frame_crc  = header_crc_next;
        status_res.last       = 1'b1;
    end

    assign n_res    = {1'b0, data_en} + {1'b0, status_en};
    assign fire     = in_valid_reg && (room >= {{(Q_CNT_W-2){1'b0}}, n_res});
    assign in_ready = !in_valid_reg || fire;

    always_comb
    begin
        push.push0 = fire && (data_en || status_en);
        push.push1 = fire && data_en && status_en;
        push.r0    = data_en ? data_res : status_res;
        push.r1    = status_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_armed_reg <= 1'b0;
            end_armed_reg   <= 1'b0;
            expect_hi_reg   <= 1'b0;
            phase_reg       <= PH_IDLE;
            crc_hi_reg      <= 8'h00;
            header_crc_reg  <= 16'h0000;
            run_crc_reg     <= CRC_INIT;
            dly_reg         <= '{8'h00, 8'h00, 8'h00};
            first_byte_reg  <= 8'h00;
            count_reg       <= 8'h00;
        end
        else if (fire)
        begin
            start_armed_reg <= start_armed_next;
            end_armed_reg   <= end_armed_next;
            expect_hi_reg   <= expect_hi_next;
            phase_reg       <= phase_next;
            crc_hi_reg      <= crc_hi_next;
            header_crc_reg  <= header_crc_next;
            run_crc_reg     <= run_crc_next;
            dly_reg         <= dly_next;
            first_byte_reg  <= first_byte_next;
            count_reg       <= count_next;
        end
    end

    a_status_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status_en |=> phase_reg == PH_IDLE && count_reg == 8'h00)
        else $error("frame end did not return parser to idle");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> push.r0.kind == KIND_DATA && !push.r0.last
                       && push.r1.kind == KIND_STATUS && push.r1.last)
        else $error("two-result beat out of order");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> room >= Q_CNT_W'(2))
        else $error("pushed two results without room");

endmodule

@@ src/fdc_out_queue.sv @@
// small result queue: takes up to two results per cycle, hands out one while out_ready is high
module fdc_out_queue
    import fdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  push_t              push,
    output logic [Q_CNT_W-1:0] room,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            head
);

    result_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic [Q_CNT_W-1:0]  n_push;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem[rd_ptr_reg];
    assign room      = Q_CNT_W'(Q_DEPTH) - count_reg;
    assign n_push    = Q_CNT_W'(push.push0) + Q_CNT_W'(push.push1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push[Q_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + n_push - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.push1) begin
            mem[wr_ptr_reg + Q_PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        Q_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |=> out_valid)
        else $error("pushed result not visible");

endmodule

@@ src/frame_deframer_crc16_check.sv @@
// top level: frame receiver with crc-16/modbus status
//
//  channel | signals                       | dir | content
//  --------+-------------------------------+-----+-------------------------------
//  in      | in_valid in_ready rx_byte     | in  | one link byte per beat
//  out     | out_valid out_ready kind ...  | out | stored byte or frame end status
//
// one input beat per cycle while the output drains; an accepted byte is registered in the core
// and its results are written into the queue before the output can accept the first of them
// a beat that closes a frame in the data phase yields two results, the byte and the status;
// the four-entry result queue takes the extra result without stalling input
// reset clears parser state, crc and queue; no clearing pass is needed
// out_ready low fills the queue, then in_ready drops until room returns
module frame_deframer_crc16_check
    import fdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  data_index,
    output logic        crc_ok,
    output logic        for_master,
    output logic [15:0] frame_crc,
    output logic        last
);

    push_t              push;
    logic [Q_CNT_W-1:0] room;
    result_t            head;

    fdc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .room     (room),
        .push     (push)
    );

    fdc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind       = head.kind;
    assign data_byte  = head.data_byte;
    assign data_index = head.data_index;
    assign crc_ok     = head.crc_ok;
    assign for_master = head.for_master;
    assign frame_crc  = head.frame_crc;
    assign last       = head.last;

endmodule

@@ verif/tb_frame_deframer_crc16_check.sv @@
// testbench for the frame deframer: drives link bytes, predicts stored bytes and frame status
module tb_frame_deframer_crc16_check;
    import fdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic        crc_ok;
        logic        for_master;
        logic [15:0] frame_crc;
        logic        last;
    } beat_t;

    typedef struct {
        logic [7:0] b;
        bit         drain;
    } link_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic        crc_ok;
    logic        for_master;
    logic [15:0] frame_crc;
    logic        last;

    frame_deframer_crc16_check u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data_byte  (data_byte),
        .data_index (data_index),
        .crc_ok     (crc_ok),
        .for_master (for_master),
        .frame_crc  (frame_crc),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver model state
    logic        m_start_seen;
    logic        m_end_seen;
    logic        m_want_crc_hi;
    phase_t      m_phase;
    logic [7:0]  m_crc_hi;
    logic [15:0] m_hdr_crc;
    logic [15:0] m_crc;
    logic [7:0]  m_dly [3];
    logic [7:0]  m_first;
    logic [7:0]  m_count;

    link_item_t  link_bytes [$];
    link_item_t  next_item;
    beat_t       pending_beats [$];
    beat_t       got_beat;
    beat_t       want_beat;

    int n_stim;
    int n_acc;
    int n_pred;
    int n_seen;
    int n_status;
    int n_good;
    int mismatches;
    int new_beats;
    int tx_gap;
    int rx_stall;
    int hold_left;
    int holds_done;
    int cycles = 0;

    // bit-serial form of the reflected modbus crc
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c;
        for (int i = 0; i < 8; i++)
        begin
            if (x[0] ^ b[i])
            begin
                x = (x >> 1) ^ CRC_POLY;
            end
            else
            begin
                x = x >> 1;
            end
        end
        return x;
    endfunction

    function automatic string beat_str(input beat_t x);
        return $sformatf("kind=%0d byte=%h idx=%0d ok=%0d fm=%0d crc=%h last=%0d",
                         x.kind, x.data_byte, x.data_index, x.crc_ok, x.for_master,
                         x.frame_crc, x.last);
    endfunction

    task automatic drop_payload();
        m_crc    = CRC_INIT;
        m_dly[0] = 8'h00;
        m_dly[1] = 8'h00;
        m_dly[2] = 8'h00;
        m_count  = 8'h00;
    endtask

    task automatic model_reset();
        m_start_seen  = 1'b0;
        m_end_seen    = 1'b0;
        m_want_crc_hi = 1'b0;
        m_phase       = PH_IDLE;
        m_crc_hi      = 8'h00;
        m_hdr_crc     = 16'h0000;
        m_first       = 8'h00;
        drop_payload();
    endtask

    // works out the results of one accepted link byte and queues them
    task automatic predict_rx_byte(input logic [7:0] b, output int n_out);
        beat_t r [2];
        int    n;
        n    = 0;
        r[0] = '0;
        r[1] = '0;
        if (b == START_MARK)
        begin
            if (!m_start_seen)
            begin
                m_start_seen = 1'b1;
            end
            else
            begin
                m_start_seen  = 1'b0;
                m_want_crc_hi = 1'b1;
                m_phase       = PH_IDLE;
                m_first       = 8'h00;
                drop_payload();
            end
        end
        else if (m_want_crc_hi)
        begin
            m_crc_hi      = b;
            m_want_crc_hi = 1'b0;
            m_phase       = PH_CRC_LO;
        end
        else if (m_phase == PH_CRC_LO)
        begin
            m_hdr_crc = {m_crc_hi, b};
            m_phase   = PH_LEN;
        end
        else if (m_phase == PH_LEN)
        begin
            m_phase = PH_DATA;
        end
        else if (m_phase == PH_DATA)
        begin
            r[n].kind       = KIND_DATA;
            r[n].data_byte  = b;
            r[n].data_index = m_count;
            n++;
            if (m_count == 8'h00)
            begin
                m_first = b;
            end
            // crc trails the payload by three bytes
            if (m_count >= CRC_SKIP)
            begin
                m_crc = crc_step(m_crc, m_dly[2]);
            end
            m_dly[2] = m_dly[1];
            m_dly[1] = m_dly[0];
            m_dly[0] = b;
            if (m_count != INDEX_MAX)
            begin
                m_count = m_count + 8'd1;
            end
        end
        if (b == END_MARK)
        begin
            if (!m_end_seen)
            begin
                m_end_seen = 1'b1;
            end
            else
            begin
                m_end_seen      = 1'b0;
                r[n].kind       = KIND_STATUS;
                r[n].crc_ok     = (m_crc == m_hdr_crc);
                r[n].for_master = (m_crc == m_hdr_crc) && (m_first == 8'h00);
                r[n].frame_crc  = m_hdr_crc;
                n++;
                m_phase = PH_IDLE;
                drop_payload();
            end
        end
        if (n > 0)
        begin
            r[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            pending_beats.push_back(r[i]);
        end
        n_out = n;
    endtask

    // any byte but the two markers
    function automatic logic [7:0] safe_byte();
        int v;
        v = $urandom_range(0, 253);
        if (v == 253)
        begin
            v = 255;
        end
        return 8'(v);
    endfunction

    task automatic add_byte(input logic [7:0] b, input bit drain);
        link_item_t it;
        it.b     = b;
        it.drain = drain;
        link_bytes.push_back(it);
    endtask

    task automatic add_frame(input int n_data, input bit zero_first, input bit bad_crc,
                             input bit drain, input bit closed);
        logic [7:0]  payload [$];
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < n_data; i++)
        begin
            payload.push_back((i == 0 && zero_first) ? 8'h00 : safe_byte());
        end
        // crc skips the last payload byte and the end pair
        for (int i = 0; i < n_data - 1; i++)
        begin
            c = crc_step(c, payload[i]);
        end
        if (bad_crc)
        begin
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        end
        add_byte(START_MARK, drain);
        add_byte(START_MARK, 1'b0);
        add_byte(c[15:8], 1'b0);
        add_byte(c[7:0], 1'b0);
        add_byte(safe_byte(), 1'b0);
        foreach (payload[i])
        begin
            add_byte(payload[i], 1'b0);
        end
        if (closed)
        begin
            add_byte(END_MARK, 1'b0);
            add_byte(END_MARK, 1'b0);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            n_acc    <= 0;
            n_pred   <= 0;
            tx_gap    = 0;
            model_reset();
        end
        else
        begin
            new_beats = 0;
            if (in_valid && in_ready)
            begin
                predict_rx_byte(rx_byte, new_beats);
                n_acc  <= n_acc + 1;
                n_pred <= n_pred + new_beats;
                // alternate stretches of back-to-back beats with random gaps
                if (n_acc[6] || $urandom_range(0, 2) != 0)
                begin
                    tx_gap = 0;
                end
                else
                begin
                    tx_gap = $urandom_range(0, 16);
                end
            end
            if (!(in_valid && !in_ready))
            begin
                if (tx_gap != 0)
                begin
                    tx_gap = tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (link_bytes.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (link_bytes[0].drain && (n_pred + new_beats != n_seen))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_item = link_bytes.pop_front();
                    rx_byte  <= next_item.b;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // long receiver hold-off so the result queue fills and input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (holds_done == 0 && n_acc >= 120)
        begin
            hold_left  <= 300;
            holds_done <= 1;
        end
        else if (holds_done == 1 && n_acc >= 420)
        begin
            hold_left  <= 300;
            holds_done <= 2;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            n_seen     <= 0;
            n_status   <= 0;
            n_good     <= 0;
            mismatches <= 0;
            rx_stall    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_beat.kind       = kind;
                got_beat.data_byte  = data_byte;
                got_beat.data_index = data_index;
                got_beat.crc_ok     = crc_ok;
                got_beat.for_master = for_master;
                got_beat.frame_crc  = frame_crc;
                got_beat.last       = last;
                n_seen <= n_seen + 1;
                if (got_beat.kind == KIND_STATUS)
                begin
                    n_status <= n_status + 1;
                    if (got_beat.crc_ok)
                    begin
                        n_good <= n_good + 1;
                    end
                end
                if (pending_beats.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected beat: %s", beat_str(got_beat));
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want_beat = pending_beats.pop_front();
                    if (got_beat !== want_beat)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("beat %0d exp: %s", n_seen, beat_str(want_beat));
                            $display("beat %0d got: %s", n_seen, beat_str(got_beat));
                        end
                        mismatches <= mismatches + 1;
                    end
                end
                if (n_seen[5] || $urandom_range(0, 2) != 0)
                begin
                    rx_stall = 0;
                end
                else
                begin
                    rx_stall = $urandom_range(0, 16);
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else if (rx_stall != 0)
            begin
                rx_stall = rx_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, n_pred - n_seen);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int left;
        int pick;

        // bytes while idle are ignored
        add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0);
        // end pair while idle, with a byte in between
        add_byte(END_MARK, 1'b0); add_byte(8'h5A, 1'b0); add_byte(END_MARK, 1'b0);
        // short frame to the master, empty crc matches ffff
        add_byte(START_MARK, 1'b1); add_byte(START_MARK, 1'b0);
        add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h03, 1'b0);
        add_byte(8'h00, 1'b0); add_byte(END_MARK, 1'b0); add_byte(END_MARK, 1'b0);
        // split start pair, lone start inside the frame, then restart
        add_byte(START_MARK, 1'b0); add_byte(8'h33, 1'b0); add_byte(START_MARK, 1'b0);
        add_byte(8'h12, 1'b0); add_byte(8'h34, 1'b0); add_byte(8'h02, 1'b0);
        add_byte(8'h41, 1'b0); add_byte(START_MARK, 1'b0); add_byte(START_MARK, 1'b0);
        add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
        // end marker split by a payload byte
        add_byte(END_MARK, 1'b0); add_byte(8'h42, 1'b0); add_byte(END_MARK, 1'b0);

        // one frame long enough to saturate the index
        add_frame(258, 1'b0, 1'b0, 1'b1, 1'b1);
        while (link_bytes.size() < 620)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 8)
            begin
                add_frame($urandom_range(0, 12), $urandom_range(0, 3) == 0, 1'b0,
                          $urandom_range(0, 7) == 0, 1'b1);
            end
            else if (pick < 10)
            begin
                add_frame($urandom_range(0, 12), $urandom_range(0, 1) == 1, 1'b1, 1'b0,
                          1'b1);
            end
            else if (pick < 12)
            begin
                // left open, the next start pair abandons it
                add_frame($urandom_range(0, 6), 1'b0, 1'b0, 1'b0, 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    case ($urandom_range(0, 3))
                        0: add_byte(START_MARK, 1'b0);
                        1: add_byte(END_MARK, 1'b0);
                        default: add_byte(8'($urandom_range(0, 255)), 1'b0);
                    endcase
                end
            end
        end
        n_stim = link_bytes.size();

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (n_acc != n_stim) @(posedge clk);
        while (n_seen != n_pred) @(posedge clk);
        repeat (20) @(posedge clk);

        left = pending_beats.size();
        if (left != 0)
        begin
            $display("%0d expected results never arrived", left);
        end
        $display("sent %0d link bytes incl. a saturating frame, noise and broken frames",
                 n_acc);
        $display("checked %0d results, %0d frame ends (%0d with good crc), %0d mismatches",
                 n_seen, n_status, n_good, mismatches);
        if (mismatches == 0 && left == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
